@@ sv/sgt_pkg.sv @@
// ----------------------------------------------------------------------------
// sgt_pkg
// shared types and codes for the sequence gap tracker
// ----------------------------------------------------------------------------
package sgt_pkg;

    localparam int SEQ_W = 64;

    typedef enum logic [2:0] {
        KIND_BASELINE = 3'd0,
        KIND_IN_ORDER = 3'd1,
        KIND_GAP_OPEN = 3'd2,
        KIND_LATE     = 3'd3,
        KIND_GAP_FILL = 3'd4,
        KIND_RANGE    = 3'd5,
        KIND_NO_RANGE = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LIMITS = 3'd1,
        ST_TRACK_LIM  = 3'd2,
        ST_RANGE_LIM  = 3'd3,
        ST_SPLIT_LIM  = 3'd4
    } status_t;

    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_LIST    = 1'b1;

    localparam logic CFG_TRACK_LIMIT = 1'b0;
    localparam logic CFG_RANGE_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SEARCH,
        S_SEARCH_CMP,
        S_SHIFT_UP,
        S_SHIFT_UP_WR,
        S_SPLIT_WR,
        S_SHIFT_DN,
        S_SHIFT_DN_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_RESULT
    } state_t;

    // range memory command (write port fields and a read address)
    typedef struct packed {
        logic            we;
        logic [11:0]     waddr;
        logic [SEQ_W-1:0] wlo;
        logic [SEQ_W-1:0] whi;
        logic [11:0]     raddr;
    } gap_cmd_t;

endpackage

@@ sv/sequence_gap_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// sequence_gap_tracker_unit
// per-track sequence number gap tracker with ordered missing-range lists
// ----------------------------------------------------------------------------
// One item at a time; ready is low from acceptance until the last result
// transfer. The key lookup walks the track table one entry a cycle, then the
// decide state classifies the item. An observe that lands behind the
// expected number, or after the top value, walks the track's ranges through
// the range memory (one write and one registered read port), with a read and
// a compare state per range; a split or a removal then moves the following
// ranges one slot, with a read and a write state per moved range, and a split
// ends with a write of the new upper range. A list item streams its ranges
// through a read and an output state per range, and the read waits while a
// held result is not yet taken. s_ready returns the cycle after the last
// transfer. The range memory holds MAX_TRACKS*MAX_GAPS entries; it needs no
// clearing since each entry is written before it is read.
// ----------------------------------------------------------------------------
module sequence_gap_tracker_unit #(
    parameter int MAX_TRACKS = 8,
    parameter int MAX_GAPS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_stream_id,
    input  logic [15:0] s_connection_id,
    input  logic [7:0]  s_format_id,
    input  logic [63:0] s_seq_num,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [2:0]  m_status,
    output logic [63:0] m_range_lo,
    output logic [63:0] m_range_hi,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int GW  = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
    localparam int TCW = $clog2(MAX_TRACKS + 1);
    localparam int GCW = $clog2(MAX_GAPS + 1);
    localparam int AW  = TW + GW;
    localparam int DEPTH = MAX_TRACKS * MAX_GAPS;

    // configuration
    logic [3:0] track_limit_reg;
    logic [4:0] range_limit_reg;

    // track table
    logic [MAX_TRACKS-1:0] track_used_reg;
    logic [7:0]  key_s_reg  [MAX_TRACKS];
    logic [15:0] key_c_reg  [MAX_TRACKS];
    logic [7:0]  key_f_reg  [MAX_TRACKS];
    logic [63:0] next_exp_reg [MAX_TRACKS];
    logic        top_reg    [MAX_TRACKS];
    logic [GCW-1:0] gcnt_reg [MAX_TRACKS];
    logic [TCW-1:0] tracks_reg;

    // item registers
    logic        func_reg;
    logic [7:0]  s_id_reg;
    logic [15:0] c_id_reg;
    logic [7:0]  f_id_reg;
    logic [63:0] seq_reg;
    logic        found_reg;
    logic [TW-1:0] trk_reg;
    logic [TCW-1:0] tidx_reg;   // lookup index
    logic [GCW-1:0] gidx_reg;   // range walk index
    logic [GCW-1:0] hit_reg;
    logic [63:0] hhi_reg;

    // result register
    logic        out_v_reg;
    sgt_pkg::kind_t   kind_reg;
    sgt_pkg::status_t stat_reg;
    logic [63:0] rlo_reg, rhi_reg;
    logic        last_reg;

    sgt_pkg::state_t state_reg, state_next;

    // limits clipped to capacity
    logic [TCW-1:0] tl;
    logic [GCW-1:0] rl;
    always_comb begin
        tl = (32'(track_limit_reg) > MAX_TRACKS) ? TCW'(MAX_TRACKS) : TCW'(track_limit_reg);
        rl = (32'(range_limit_reg) > MAX_GAPS) ? GCW'(MAX_GAPS) : GCW'(range_limit_reg);
    end

    // range memory
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0]   mem_wlo, mem_whi, mem_rlo, mem_rhi;

    sgt_gap_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .aclk (aclk), .we (mem_we), .waddr (mem_wa), .wlo (mem_wlo), .whi (mem_whi),
        .raddr (mem_ra), .rlo (mem_rlo), .rhi (mem_rhi)
    );

    function automatic logic [AW-1:0] maddr(input logic [TW-1:0] t, input logic [GCW-1:0] g);
        maddr = {t, g[GW-1:0]};
    endfunction

    // current track fields
    logic [GCW-1:0] n_cur;
    logic [63:0]    nexp_cur;
    logic           top_cur;
    logic           key_hit;
    logic [TW-1:0]  tix;
    always_comb begin
        tix      = tidx_reg[TW-1:0];
        n_cur    = gcnt_reg[trk_reg];
        nexp_cur = next_exp_reg[trk_reg];
        top_cur  = top_reg[trk_reg];
        key_hit  = track_used_reg[tix] && key_s_reg[tix] == s_id_reg
                   && key_c_reg[tix] == c_id_reg && key_f_reg[tix] == f_id_reg;
    end

    // shared compare unit: the walked range vs the frame
    logic in_rng;
    assign in_rng = (seq_reg >= mem_rlo) && (seq_reg < mem_rhi);

    logic s_acc, m_acc;
    assign s_ready   = (state_reg == sgt_pkg::S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign m_acc     = m_valid && m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_v_reg;
    assign m_kind    = kind_reg;
    assign m_status  = stat_reg;
    assign m_range_lo = rlo_reg;
    assign m_range_hi = rhi_reg;
    assign m_last    = last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sgt_pkg::S_IDLE:
                if (s_acc) state_next = sgt_pkg::S_LOOKUP;
            sgt_pkg::S_LOOKUP:
                if (tl == '0 || rl == '0 || key_hit || tidx_reg + 1'b1 >= tracks_reg
                    || tidx_reg >= tracks_reg)
                    state_next = sgt_pkg::S_DECIDE;
            sgt_pkg::S_DECIDE:
                if (tl == '0 || rl == '0) state_next = sgt_pkg::S_RESULT;
                else if (func_reg == sgt_pkg::FUNC_LIST)
                    state_next = (found_reg && n_cur != '0) ? sgt_pkg::S_LIST_RD
                                                             : sgt_pkg::S_RESULT;
                else if (!found_reg) state_next = sgt_pkg::S_RESULT;
                else if (!top_cur && seq_reg >= nexp_cur) state_next = sgt_pkg::S_RESULT;
                else state_next = (n_cur == '0) ? sgt_pkg::S_RESULT : sgt_pkg::S_SEARCH;
            sgt_pkg::S_SEARCH:
                state_next = sgt_pkg::S_SEARCH_CMP;
            sgt_pkg::S_SEARCH_CMP:
                if (in_rng) begin
                    if (seq_reg != mem_rlo && seq_reg + 64'd1 != mem_rhi)
                        state_next = (n_cur >= rl) ? sgt_pkg::S_RESULT
                                   : (n_cur == gidx_reg + 1'b1) ? sgt_pkg::S_SPLIT_WR
                                                                : sgt_pkg::S_SHIFT_UP;
                    else if (seq_reg == mem_rlo && seq_reg + 64'd1 == mem_rhi)
                        state_next = (gidx_reg + 1'b1 >= n_cur) ? sgt_pkg::S_RESULT
                                                                : sgt_pkg::S_SHIFT_DN;
                    else state_next = sgt_pkg::S_RESULT;
                end else if (gidx_reg + 1'b1 >= n_cur) state_next = sgt_pkg::S_RESULT;
                else state_next = sgt_pkg::S_SEARCH;
            sgt_pkg::S_SHIFT_UP:
                state_next = sgt_pkg::S_SHIFT_UP_WR;
            sgt_pkg::S_SHIFT_UP_WR:
                // the slot just past the hit is written by the split itself
                state_next = (gidx_reg == hit_reg + 2'd2) ? sgt_pkg::S_SPLIT_WR
                                                          : sgt_pkg::S_SHIFT_UP;
            sgt_pkg::S_SPLIT_WR:
                state_next = sgt_pkg::S_RESULT;
            sgt_pkg::S_SHIFT_DN:
                state_next = sgt_pkg::S_SHIFT_DN_WR;
            sgt_pkg::S_SHIFT_DN_WR:
                // n_cur already holds the count after the removal
                state_next = (gidx_reg + 1'b1 >= n_cur) ? sgt_pkg::S_RESULT
                                                        : sgt_pkg::S_SHIFT_DN;
            sgt_pkg::S_LIST_RD:
                if (!out_v_reg || m_ready) state_next = sgt_pkg::S_LIST_OUT;
            sgt_pkg::S_LIST_OUT:
                state_next = (gidx_reg + 1'b1 >= n_cur) ? sgt_pkg::S_RESULT
                                                        : sgt_pkg::S_LIST_RD;
            sgt_pkg::S_RESULT:
                if (out_v_reg && m_acc && m_last) state_next = sgt_pkg::S_IDLE;
            default: state_next = sgt_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = maddr(trk_reg, gidx_reg);
        mem_wlo = mem_rlo;
        mem_whi = mem_rhi;
        mem_ra  = maddr(trk_reg, gidx_reg);
        case (state_reg)
            sgt_pkg::S_DECIDE: begin
                mem_ra = maddr(trk_reg, '0);
                if (func_reg == sgt_pkg::FUNC_OBSERVE && found_reg && !top_cur
                    && seq_reg > nexp_cur && n_cur < rl && tl != '0) begin
                    mem_we  = 1'b1;
                    mem_wa  = maddr(trk_reg, n_cur);
                    mem_wlo = nexp_cur;
                    mem_whi = seq_reg;
                end
            end
            sgt_pkg::S_SEARCH_CMP:
                if (in_rng) begin
                    if (seq_reg == mem_rlo && seq_reg + 64'd1 != mem_rhi) begin
                        mem_we  = 1'b1;
                        mem_wlo = seq_reg + 64'd1;
                    end else if (seq_reg != mem_rlo && seq_reg + 64'd1 == mem_rhi) begin
                        mem_we  = 1'b1;
                        mem_whi = seq_reg;
                    end else if (seq_reg != mem_rlo && n_cur < rl) begin
                        mem_we  = 1'b1;
                        mem_whi = seq_reg;
                    end
                end
            sgt_pkg::S_SHIFT_UP:
                mem_ra = maddr(trk_reg, gidx_reg - 1'b1);
            sgt_pkg::S_SHIFT_UP_WR: begin
                mem_we = 1'b1;
            end
            sgt_pkg::S_SPLIT_WR: begin
                mem_we  = 1'b1;
                mem_wa  = maddr(trk_reg, hit_reg + 1'b1);
                mem_wlo = seq_reg + 64'd1;
                mem_whi = hhi_reg;
            end
            sgt_pkg::S_SHIFT_DN:
                mem_ra = maddr(trk_reg, gidx_reg + 1'b1);
            sgt_pkg::S_SHIFT_DN_WR:
                mem_we = 1'b1;
            default: ;
        endcase
    end

    // datapath and table updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sgt_pkg::S_IDLE;
            track_limit_reg <= 4'd8;
            range_limit_reg <= 5'd16;
            track_used_reg  <= '0;
            tracks_reg      <= '0;
            out_v_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == sgt_pkg::CFG_TRACK_LIMIT) track_limit_reg <= cfg_data[3:0];
                else range_limit_reg <= cfg_data;
            end
            if (m_acc) out_v_reg <= 1'b0;
            case (state_reg)
                sgt_pkg::S_IDLE:
                    if (s_acc) begin
                        func_reg  <= s_func;
                        s_id_reg  <= s_stream_id;
                        c_id_reg  <= s_connection_id;
                        f_id_reg  <= s_format_id;
                        seq_reg   <= s_seq_num;
                        found_reg <= 1'b0;
                        tidx_reg  <= '0;
                    end
                sgt_pkg::S_LOOKUP:
                    if (tidx_reg < tracks_reg && key_hit) begin
                        found_reg <= 1'b1;
                        trk_reg   <= tix;
                    end else if (tidx_reg < tracks_reg) begin
                        tidx_reg <= tidx_reg + 1'b1;
                    end
                sgt_pkg::S_DECIDE: begin
                    gidx_reg  <= '0;
                    out_v_reg <= 1'b1;
                    last_reg  <= 1'b1;
                    rlo_reg   <= '0;
                    rhi_reg   <= '0;
                    stat_reg  <= sgt_pkg::ST_OK;
                    kind_reg  <= sgt_pkg::KIND_LATE;
                    if (tl == '0 || rl == '0) begin
                        kind_reg <= sgt_pkg::KIND_BASELINE;
                        stat_reg <= sgt_pkg::ST_BAD_LIMITS;
                    end else if (func_reg == sgt_pkg::FUNC_LIST) begin
                        out_v_reg <= !(found_reg && n_cur != '0);
                        kind_reg  <= sgt_pkg::KIND_NO_RANGE;
                    end else if (!found_reg) begin
                        kind_reg <= sgt_pkg::KIND_BASELINE;
                        if (tracks_reg >= tl) begin
                            stat_reg <= sgt_pkg::ST_TRACK_LIM;
                        end else begin
                            track_used_reg[tracks_reg[TW-1:0]] <= 1'b1;
                            key_s_reg[tracks_reg[TW-1:0]] <= s_id_reg;
                            key_c_reg[tracks_reg[TW-1:0]] <= c_id_reg;
                            key_f_reg[tracks_reg[TW-1:0]] <= f_id_reg;
                            gcnt_reg[tracks_reg[TW-1:0]]  <= '0;
                            top_reg[tracks_reg[TW-1:0]]   <= &seq_reg;
                            next_exp_reg[tracks_reg[TW-1:0]] <= (&seq_reg) ? 64'd0
                                                                : seq_reg + 64'd1;
                            tracks_reg <= tracks_reg + 1'b1;
                        end
                    end else if (!top_cur && seq_reg == nexp_cur) begin
                        kind_reg <= sgt_pkg::KIND_IN_ORDER;
                        if (&seq_reg) top_reg[trk_reg] <= 1'b1;
                        else next_exp_reg[trk_reg] <= seq_reg + 64'd1;
                    end else if (!top_cur && seq_reg > nexp_cur) begin
                        if (n_cur >= rl) begin
                            kind_reg <= sgt_pkg::KIND_BASELINE;
                            stat_reg <= sgt_pkg::ST_RANGE_LIM;
                        end else begin
                            kind_reg <= sgt_pkg::KIND_GAP_OPEN;
                            rlo_reg  <= nexp_cur;
                            rhi_reg  <= seq_reg;
                            gcnt_reg[trk_reg] <= n_cur + 1'b1;
                            if (&seq_reg) top_reg[trk_reg] <= 1'b1;
                            else next_exp_reg[trk_reg] <= seq_reg + 64'd1;
                        end
                    end else if (n_cur != '0) begin
                        out_v_reg <= 1'b0;
                    end
                end
                sgt_pkg::S_SEARCH_CMP:
                    if (in_rng) begin
                        hit_reg   <= gidx_reg;
                        hhi_reg   <= mem_rhi;
                        // result goes out only once the range moves are done
                        out_v_reg <= (state_next == sgt_pkg::S_RESULT);
                        kind_reg  <= sgt_pkg::KIND_GAP_FILL;
                        rlo_reg   <= seq_reg;
                        rhi_reg   <= seq_reg + 64'd1;
                        if (seq_reg != mem_rlo && seq_reg + 64'd1 != mem_rhi) begin
                            if (n_cur >= rl) begin
                                kind_reg <= sgt_pkg::KIND_BASELINE;
                                stat_reg <= sgt_pkg::ST_SPLIT_LIM;
                                rlo_reg  <= '0;
                                rhi_reg  <= '0;
                            end else begin
                                gcnt_reg[trk_reg] <= n_cur + 1'b1;
                                gidx_reg <= n_cur;
                            end
                        end else if (seq_reg == mem_rlo && seq_reg + 64'd1 == mem_rhi) begin
                            gcnt_reg[trk_reg] <= n_cur - 1'b1;
                        end
                    end else if (gidx_reg + 1'b1 >= n_cur) begin
                        out_v_reg <= 1'b1;
                    end else begin
                        gidx_reg <= gidx_reg + 1'b1;
                    end
                sgt_pkg::S_SHIFT_UP_WR:
                    gidx_reg <= gidx_reg - 1'b1;
                sgt_pkg::S_SPLIT_WR:
                    out_v_reg <= 1'b1;
                sgt_pkg::S_SHIFT_DN_WR: begin
                    gidx_reg <= gidx_reg + 1'b1;
                    if (state_next == sgt_pkg::S_RESULT) out_v_reg <= 1'b1;
                end
                sgt_pkg::S_LIST_OUT: begin
                    out_v_reg <= 1'b1;
                    kind_reg  <= sgt_pkg::KIND_RANGE;
                    stat_reg  <= sgt_pkg::ST_OK;
                    rlo_reg   <= mem_rlo;
                    rhi_reg   <= mem_rhi;
                    last_reg  <= (gidx_reg + 1'b1 >= n_cur);
                    gidx_reg  <= gidx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sgt_pkg::S_IDLE) |-> !s_ready)
        else $error("ready while busy");
    a_tracks_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(tracks_reg) <= MAX_TRACKS)
        else $error("track count overflow");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_last) |=> (state_reg == sgt_pkg::S_IDLE))
        else $error("last result did not end item");
endmodule

@@ sv/sgt_gap_mem.sv @@
// ----------------------------------------------------------------------------
// sgt_gap_mem
// range store: one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sgt_gap_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [sgt_pkg::SEQ_W-1:0] wlo,
    input  logic [sgt_pkg::SEQ_W-1:0] whi,
    input  logic [AW-1:0]             raddr,
    output logic [sgt_pkg::SEQ_W-1:0] rlo,
    output logic [sgt_pkg::SEQ_W-1:0] rhi
);
    logic [2*sgt_pkg::SEQ_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wlo, whi};
        end
        {rlo, rhi} <= mem[raddr];
    end
endmodule

@@ test/tb_sequence_gap_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sequence_gap_tracker_unit
// self-checking bench for the sequence gap tracker: a driver and a monitor
// around the unit, with a predictor of track and range state that forms the
// expected result transfers for every accepted item
// ----------------------------------------------------------------------------
module tb_sequence_gap_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTRK = 8;
    localparam int NGAP = 16;
    localparam logic [63:0] SEQ_TOP = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        func;
        logic [7:0]  stream;
        logic [15:0] conn;
        logic [7:0]  fmt;
        logic [63:0] seq;
    } frame_t;

    typedef struct packed {
        sgt_pkg::kind_t   kind;
        sgt_pkg::status_t status;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        last;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [7:0]  s_stream_id = '0;
    logic [15:0] s_connection_id = '0;
    logic [7:0]  s_format_id = '0;
    logic [63:0] s_seq_num = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [2:0]  m_status;
    logic [63:0] m_range_lo;
    logic [63:0] m_range_hi;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [4:0]  cfg_data = '0;

    sequence_gap_tracker_unit dut (.*);

    always #5 aclk = ~aclk;

    // predictor state, a private copy of the unit's tables
    int unsigned lim_tracks, lim_ranges, n_tracks;
    logic [7:0]  trk_stream [NTRK];
    logic [15:0] trk_conn [NTRK];
    logic [7:0]  trk_fmt [NTRK];
    logic [63:0] trk_next [NTRK];
    logic        trk_top [NTRK];
    int unsigned trk_ngap [NTRK];
    logic [63:0] rng_lo [NTRK][NGAP];
    logic [63:0] rng_hi [NTRK][NGAP];

    frame_t   frame_q[$];
    verdict_t verdict_q[$];
    int errors = 0;
    int frames_sent = 0, verdicts_seen = 0, list_items = 0;
    logic stall_hold = 1'b0;
    logic rx_enable = 1'b0;

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic void queue_verdict(sgt_pkg::kind_t k, sgt_pkg::status_t s,
                                          logic [63:0] lo, logic [63:0] hi, logic last);
        verdict_t v;
        v.kind = k; v.status = s; v.lo = lo; v.hi = hi; v.last = last;
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    function automatic void advance_track(int t, logic [63:0] sq);
        if (sq == SEQ_TOP) trk_top[t] = 1'b1;
        else trk_next[t] = sq + 64'd1;
    endfunction

    // classify one frame against the predicted state and queue its verdicts
    function automatic void track_frame(frame_t f);
        int unsigned tl, rl, n, hit;
        int t;
        logic [63:0] lo, hi, nx;
        tl = lim_tracks > NTRK ? NTRK : lim_tracks;
        rl = lim_ranges > NGAP ? NGAP : lim_ranges;
        if (tl == 0 || rl == 0) begin
            queue_verdict(sgt_pkg::KIND_BASELINE, sgt_pkg::ST_BAD_LIMITS, 64'd0, 64'd0, 1'b1);
            return;
        end
        t = -1;
        for (int i = 0; i < n_tracks; i++)
            if (t < 0 && trk_stream[i] == f.stream && trk_conn[i] == f.conn
                && trk_fmt[i] == f.fmt) t = i;
        if (f.func == sgt_pkg::FUNC_LIST) begin
            if (t < 0 || trk_ngap[t] == 0) begin
                queue_verdict(sgt_pkg::KIND_NO_RANGE, sgt_pkg::ST_OK, 64'd0, 64'd0, 1'b1);
                return;
            end
            for (int i = 0; i < trk_ngap[t]; i++)
                queue_verdict(sgt_pkg::KIND_RANGE, sgt_pkg::ST_OK, rng_lo[t][i], rng_hi[t][i],
                              i + 1 == trk_ngap[t]);
            return;
        end
        if (t < 0) begin
            if (n_tracks >= tl) begin
                queue_verdict(sgt_pkg::KIND_BASELINE, sgt_pkg::ST_TRACK_LIM, 64'd0, 64'd0,
                              1'b1);
                return;
            end
            t = n_tracks++;
            trk_stream[t] = f.stream; trk_conn[t] = f.conn; trk_fmt[t] = f.fmt;
            trk_next[t] = 0; trk_top[t] = 1'b0; trk_ngap[t] = 0;
            advance_track(t, f.seq);
            queue_verdict(sgt_pkg::KIND_BASELINE, sgt_pkg::ST_OK, 64'd0, 64'd0, 1'b1);
            return;
        end
        n = trk_ngap[t];
        if (!trk_top[t] && f.seq == trk_next[t]) begin
            advance_track(t, f.seq);
            queue_verdict(sgt_pkg::KIND_IN_ORDER, sgt_pkg::ST_OK, 64'd0, 64'd0, 1'b1);
            return;
        end
        if (!trk_top[t] && f.seq > trk_next[t]) begin
            lo = trk_next[t];
            if (n >= rl) begin
                queue_verdict(sgt_pkg::KIND_BASELINE, sgt_pkg::ST_RANGE_LIM, 64'd0, 64'd0,
                              1'b1);
                return;
            end
            rng_lo[t][n] = lo; rng_hi[t][n] = f.seq; trk_ngap[t] = n + 1;
            advance_track(t, f.seq);
            queue_verdict(sgt_pkg::KIND_GAP_OPEN, sgt_pkg::ST_OK, lo, f.seq, 1'b1);
            return;
        end
        hit = n;
        for (int i = n - 1; i >= 0; i--)
            if (f.seq >= rng_lo[t][i] && f.seq < rng_hi[t][i]) hit = i;
        if (hit == n) begin
            queue_verdict(sgt_pkg::KIND_LATE, sgt_pkg::ST_OK, 64'd0, 64'd0, 1'b1);
            return;
        end
        lo = rng_lo[t][hit]; hi = rng_hi[t][hit]; nx = f.seq + 64'd1;
        if (f.seq != lo && nx != hi) begin
            // interior hit splits the range in two
            if (n >= rl) begin
                queue_verdict(sgt_pkg::KIND_BASELINE, sgt_pkg::ST_SPLIT_LIM, 64'd0, 64'd0,
                              1'b1);
                return;
            end
            for (int i = n; i > hit + 1; i--) begin
                rng_lo[t][i] = rng_lo[t][i-1]; rng_hi[t][i] = rng_hi[t][i-1];
            end
            rng_hi[t][hit] = f.seq;
            rng_lo[t][hit+1] = nx; rng_hi[t][hit+1] = hi;
            trk_ngap[t] = n + 1;
        end else if (f.seq == lo && nx == hi) begin
            for (int i = hit; i + 1 < n; i++) begin
                rng_lo[t][i] = rng_lo[t][i+1]; rng_hi[t][i] = rng_hi[t][i+1];
            end
            trk_ngap[t] = n - 1;
        end else if (f.seq == lo) begin
            rng_lo[t][hit] = nx;
        end else begin
            rng_hi[t][hit] = f.seq;
        end
        queue_verdict(sgt_pkg::KIND_GAP_FILL, sgt_pkg::ST_OK, f.seq, nx, 1'b1);
    endfunction

    // driver: one frame per transfer, random gap after each
    int tx_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                track_frame({s_func, s_stream_id, s_connection_id, s_format_id,
                             s_seq_num});
                frames_sent++;
                if (s_func == sgt_pkg::FUNC_LIST) list_items++;
            end
            if (!s_valid || s_ready) begin
                if (tx_wait > 0) begin
                    tx_wait <= tx_wait - 1;
                    s_valid <= 1'b0;
                end else if (frame_q.size() > 0) begin
                    frame_t f;
                    f = frame_q.pop_front();
                    s_valid <= 1'b1;
                    s_func <= f.func;
                    s_stream_id <= f.stream;
                    s_connection_id <= f.conn;
                    s_format_id <= f.fmt;
                    s_seq_num <= f.seq;
                    tx_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    int rx_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    report("result transfer with nothing expected");
                end else begin
                    verdict_t v;
                    v = verdict_q.pop_front();
                    if (m_kind !== v.kind)
                        report($sformatf("kind %0d, want %0d", m_kind, v.kind));
                    if (m_status !== v.status)
                        report($sformatf("status %0d, want %0d", m_status, v.status));
                    if (m_range_lo !== v.lo)
                        report($sformatf("range_lo %h, want %h", m_range_lo, v.lo));
                    if (m_range_hi !== v.hi)
                        report($sformatf("range_hi %h, want %h", m_range_hi, v.hi));
                    if (m_last !== v.last)
                        report($sformatf("last %b, want %b", m_last, v.last));
                end
            end
            if (stall_hold || !rx_enable) begin
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                m_ready <= (rx_wait == 0);
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= (rx_wait == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic idx, input logic [4:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == sgt_pkg::CFG_TRACK_LIMIT) lim_tracks = val[3:0];
        else lim_ranges = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (frame_q.size() > 0 || s_valid || verdict_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic void add(logic fn, logic [7:0] st, logic [15:0] cn,
                                logic [7:0] fm, logic [63:0] sq);
        frame_q.insert(frame_q.size(), {fn, st, cn, fm, sq});
    endfunction

    // random key from a small pool so tracks are hit again and again
    function automatic void add_random();
        int k;
        logic [63:0] sq;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0: sq = {$urandom, $urandom};
            1: sq = SEQ_TOP - 64'($urandom_range(0, 40));
            default: sq = 64'($urandom_range(0, 60));
        endcase
        if ($urandom_range(0, 15) == 0)
            add(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), 8'($urandom), sq);
        else
            add($urandom_range(0, 4) == 0 ? sgt_pkg::FUNC_LIST : sgt_pkg::FUNC_OBSERVE,
                k == 9 ? 8'hFF : 8'(k), k[0] ? 16'hFFFF : 16'h0000,
                k[1] ? 8'hFF : 8'h00, sq);
    endfunction

    // long receiver hold-off in the middle of the random traffic
    initial begin
        wait (aresetn);
        wait (frames_sent >= 60);
        @(posedge aclk);
        stall_hold <= 1'b1;
        repeat (400) @(posedge aclk);
        stall_hold <= 1'b0;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        lim_tracks = 8; lim_ranges = 16; n_tracks = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        rx_enable <= 1'b1;

        // directed: baseline, in order, gaps, fills, top value, lists
        add(sgt_pkg::FUNC_LIST, 8'h00, 16'h0000, 8'h00, 0);            // unknown track
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd10);    // baseline
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd11);    // in order
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd20);    // gap [12,20)
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd12);    // trim low end
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd19);    // trim high end
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd15);    // split
        add(sgt_pkg::FUNC_LIST, 8'h00, 16'h0000, 8'h00, 0);
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd5);     // late
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd20);    // replay
        add(sgt_pkg::FUNC_OBSERVE, 8'hFF, 16'hFFFF, 8'hFF, SEQ_TOP);   // baseline at top
        add(sgt_pkg::FUNC_OBSERVE, 8'hFF, 16'hFFFF, 8'hFF, SEQ_TOP);   // late after top
        add(sgt_pkg::FUNC_OBSERVE, 8'h01, 16'h0000, 8'h00, 64'd0);
        add(sgt_pkg::FUNC_OBSERVE, 8'h01, 16'h0000, 8'h00, SEQ_TOP);   // gap to top
        add(sgt_pkg::FUNC_OBSERVE, 8'h01, 16'h0000, 8'h00, SEQ_TOP - 1); // fill high end
        add(sgt_pkg::FUNC_OBSERVE, 8'h01, 16'h0000, 8'h00, 64'd1);     // fill low end
        add(sgt_pkg::FUNC_LIST, 8'h01, 16'h0000, 8'h00, SEQ_TOP);
        add(sgt_pkg::FUNC_OBSERVE, 8'h02, 16'h0000, 8'h00, 64'd0);
        add(sgt_pkg::FUNC_OBSERVE, 8'h02, 16'h0000, 8'h00, 64'd2);     // gap of one
        add(sgt_pkg::FUNC_OBSERVE, 8'h02, 16'h0000, 8'h00, 64'd1);     // removes it
        add(sgt_pkg::FUNC_LIST, 8'h02, 16'h0000, 8'h00, 0);            // empty list
        drain();

        // tight limits: track and range refusals, then zero limits
        cfg_write(sgt_pkg::CFG_TRACK_LIMIT, 5'd3);
        cfg_write(sgt_pkg::CFG_RANGE_LIMIT, 5'd2);
        add(sgt_pkg::FUNC_OBSERVE, 8'h07, 16'h0001, 8'h01, 0);         // track limit
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd30);    // range limit
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 64'd17);    // split refused
        for (int i = 0; i < 30; i++) add_random();
        drain();
        cfg_write(sgt_pkg::CFG_TRACK_LIMIT, 5'd0);
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 0);
        add(sgt_pkg::FUNC_LIST, 8'h00, 16'h0000, 8'h00, 0);
        drain();
        cfg_write(sgt_pkg::CFG_TRACK_LIMIT, 5'd15);
        cfg_write(sgt_pkg::CFG_RANGE_LIMIT, 5'd0);
        add(sgt_pkg::FUNC_OBSERVE, 8'h00, 16'h0000, 8'h00, 0);
        drain();
        cfg_write(sgt_pkg::CFG_RANGE_LIMIT, 5'd31);

        // random part, with a burst of gap openings to fill range lists
        for (int i = 0; i < 16; i++)
            add(sgt_pkg::FUNC_OBSERVE, 8'h03, 16'h0000, 8'h00, 64'(i * 3));
        add(sgt_pkg::FUNC_LIST, 8'h03, 16'h0000, 8'h00, 0);
        for (int i = 0; i < 110; i++) add_random();
        drain();
        cfg_write(sgt_pkg::CFG_RANGE_LIMIT, 5'd1);
        cfg_write(sgt_pkg::CFG_TRACK_LIMIT, 5'd8);
        for (int i = 0; i < 20; i++) add_random();
        drain();

        $display("covered %0d items (%0d lists), %0d result transfers checked",
                 frames_sent, list_items, verdicts_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
